### sv/tmcg_pkg.sv
// Shared types and constants for the text-mode character generator.
`timescale 1ns / 1ps

package tmcg_pkg;

  localparam int MEM_BYTES       = 65536;
  localparam int ADDR_W          = $clog2(MEM_BYTES);
  localparam int CHARS_PER_ROW   = 80;
  localparam int PIXELS_PER_LINE = 640;
  localparam int X_W             = $clog2(PIXELS_PER_LINE);
  localparam int CELL_PIXELS     = 8;
  localparam int PIX_W           = $clog2(CELL_PIXELS);
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_RENDER = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_BASE = 2'd0,
    REG_FONT_BASE   = 2'd1,
    REG_FORE_COLOUR = 2'd2,
    REG_BACK_COLOUR = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_GLYPH,
    BK_LOAD,
    BK_EMIT
  } back_state_t;

  // Queued item: for a render the address is already the character code address.
  typedef struct packed {
    cmd_t              kind;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
    logic [7:0]        line;
    logic [6:0]        column;
  } item_t;

  typedef struct packed {
    logic [15:0] screen_base;
    logic [15:0] font_base;
    logic [31:0] fore_colour;
    logic [31:0] back_colour;
  } cfg_t;

endpackage

### sv/tmcg_front.sv
// Front end: accepts items, works out the character code address, queues them.
`timescale 1ns / 1ps

module tmcg_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_command,
  input  logic [15:0]          in_mem_address,
  input  logic [7:0]           in_mem_data,
  input  logic [7:0]           in_scan_line,
  input  logic [6:0]           in_char_column,
  input  tmcg_pkg::cfg_t       cfg,
  input  logic                 pop,
  output logic                 q_valid,
  output tmcg_pkg::item_t      q_head
);

  tmcg_pkg::item_t                       q_r [tmcg_pkg::QUEUE_DEPTH];
  logic [tmcg_pkg::QPTR_W-1:0]           wr_ptr_r, wr_ptr_nxt;
  logic [tmcg_pkg::QPTR_W-1:0]           rd_ptr_r, rd_ptr_nxt;
  logic [tmcg_pkg::QPTR_W:0]             count_r, count_nxt;
  logic                                  push;
  logic                                  do_pop;
  tmcg_pkg::item_t                       entry;
  logic [tmcg_pkg::ADDR_W-1:0]           code_addr;

  // screen_base + (line/8)*CHARS_PER_ROW + column, wrapped to the memory size
  assign code_addr = cfg.screen_base[tmcg_pkg::ADDR_W-1:0]
                   + tmcg_pkg::ADDR_W'(32'(in_scan_line >> 3) * tmcg_pkg::CHARS_PER_ROW)
                   + tmcg_pkg::ADDR_W'(in_char_column);

  always_comb begin
    entry.kind   = tmcg_pkg::cmd_t'(in_command);
    entry.addr   = (entry.kind == tmcg_pkg::CMD_RENDER) ? code_addr
                                                        : in_mem_address[tmcg_pkg::ADDR_W-1:0];
    entry.wdata  = in_mem_data;
    entry.line   = in_scan_line;
    entry.column = in_char_column;
  end

  assign busy    = (count_r == (tmcg_pkg::QPTR_W+1)'(tmcg_pkg::QUEUE_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (count_r != '0);
  assign do_pop  = pop && q_valid;
  assign q_head  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= entry;
    end
  end

endmodule

### sv/tmcg_back.sv
// Back end: display memory, code and glyph lookups, pixel serialiser.
`timescale 1ns / 1ps

module tmcg_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  tmcg_pkg::item_t                q_head,
  output logic                           pop,
  input  tmcg_pkg::cfg_t                 cfg,
  output logic                           out_valid,
  output logic [31:0]                    out_pixel_colour,
  output logic [tmcg_pkg::X_W-1:0]       out_pixel_x,
  output logic [7:0]                     out_pixel_y,
  output logic                           out_last_pixel
);

  localparam logic [tmcg_pkg::PIX_W-1:0] LAST_PIX = tmcg_pkg::PIX_W'(tmcg_pkg::CELL_PIXELS - 1);

  logic [7:0]                        mem [tmcg_pkg::MEM_BYTES];
  logic [7:0]                        rd_data_r;
  logic                              mem_we;
  logic [tmcg_pkg::ADDR_W-1:0]       mem_addr;

  tmcg_pkg::back_state_t             state_r, state_nxt;
  logic [7:0]                        line_r, line_nxt;
  logic [6:0]                        col_r, col_nxt;
  logic [7:0]                        glyph_r, glyph_nxt;
  logic [tmcg_pkg::PIX_W-1:0]        pix_r, pix_nxt;

  always_comb begin
    state_nxt = state_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    glyph_nxt = glyph_r;
    pix_nxt   = pix_r;
    pop       = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = q_head.addr;
    case (state_r)
      tmcg_pkg::BK_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          if (q_head.kind == tmcg_pkg::CMD_WRITE) begin
            mem_we = 1'b1;
          end else begin
            // code read issued straight from the queue head
            line_nxt  = q_head.line;
            col_nxt   = q_head.column;
            state_nxt = tmcg_pkg::BK_GLYPH;
          end
        end
      end
      tmcg_pkg::BK_GLYPH: begin
        mem_addr  = cfg.font_base[tmcg_pkg::ADDR_W-1:0]
                  + tmcg_pkg::ADDR_W'(line_r[2:0])
                  + tmcg_pkg::ADDR_W'({rd_data_r, 3'b000});
        state_nxt = tmcg_pkg::BK_LOAD;
      end
      tmcg_pkg::BK_LOAD: begin
        glyph_nxt = rd_data_r;
        pix_nxt   = '0;
        state_nxt = tmcg_pkg::BK_EMIT;
      end
      tmcg_pkg::BK_EMIT: begin
        glyph_nxt = {glyph_r[6:0], 1'b0};
        pix_nxt   = pix_r + 1'b1;
        if (pix_r == LAST_PIX) begin
          state_nxt = tmcg_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = tmcg_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tmcg_pkg::BK_IDLE;
      pix_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pix_r   <= pix_nxt;
    end
  end

  always_ff @(posedge clk) begin
    line_r  <= line_nxt;
    col_r   <= col_nxt;
    glyph_r <= glyph_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= q_head.wdata;
    end
    rd_data_r <= mem[mem_addr];
  end

  assign out_valid        = (state_r == tmcg_pkg::BK_EMIT);
  assign out_pixel_colour = glyph_r[7] ? cfg.fore_colour : cfg.back_colour;
  assign out_pixel_x      = tmcg_pkg::X_W'({col_r, pix_r});
  assign out_pixel_y      = line_r;
  assign out_last_pixel   = out_valid && (pix_r == LAST_PIX);

endmodule

### sv/text_mode_char_generator.sv
// Text-mode 8x8 character generator, top level with configuration registers.
//
// Items enter on start while busy is low and pass through a two-entry queue to
// the back end, which owns a single-port 64 KiB display memory. A write item
// uses that port in the cycle it is popped. A render item runs the character
// code read, the dependent glyph read, a load step, then eight pixels on
// consecutive cycles, leftmost first, out_last_pixel on the eighth. The two
// dependent reads through the one memory port and the one pixel per cycle
// output set how long a render takes. Results are strobed by out_valid for a
// single cycle and cannot be held off. The display memory is not cleared at
// reset; load screen and font before rendering.
`timescale 1ns / 1ps

module text_mode_char_generator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_command,
  input  logic [15:0]                       in_mem_address,
  input  logic [7:0]                        in_mem_data,
  input  logic [7:0]                        in_scan_line,
  input  logic [6:0]                        in_char_column,
  output logic                              out_valid,
  output logic [31:0]                       out_pixel_colour,
  output logic [9:0]                        out_pixel_x,
  output logic [7:0]                        out_pixel_y,
  output logic                              out_last_pixel,
  input  logic                              cfg_we,
  input  logic [tmcg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tmcg_pkg::CFG_DATA_W-1:0]   cfg_data
);

  tmcg_pkg::cfg_t                   cfg_r, cfg_nxt;
  logic                             q_valid;
  tmcg_pkg::item_t                  q_head;
  logic                             pop;
  logic [tmcg_pkg::X_W-1:0]         pixel_x;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (tmcg_pkg::reg_idx_t'(cfg_index))
        tmcg_pkg::REG_SCREEN_BASE: cfg_nxt.screen_base = cfg_data[15:0];
        tmcg_pkg::REG_FONT_BASE:   cfg_nxt.font_base   = cfg_data[15:0];
        tmcg_pkg::REG_FORE_COLOUR: cfg_nxt.fore_colour = cfg_data[31:0];
        tmcg_pkg::REG_BACK_COLOUR: cfg_nxt.back_colour = cfg_data[31:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_base <= '0;
      cfg_r.font_base   <= '0;
      cfg_r.fore_colour <= '1;
      cfg_r.back_colour <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tmcg_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_mem_address (in_mem_address),
    .in_mem_data    (in_mem_data),
    .in_scan_line   (in_scan_line),
    .in_char_column (in_char_column),
    .cfg            (cfg_r),
    .pop            (pop),
    .q_valid        (q_valid),
    .q_head         (q_head)
  );

  tmcg_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .pop              (pop),
    .cfg              (cfg_r),
    .out_valid        (out_valid),
    .out_pixel_colour (out_pixel_colour),
    .out_pixel_x      (pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_last_pixel   (out_last_pixel)
  );

  assign out_pixel_x = 10'(pixel_x);

endmodule

### sv/tmcg_checker.sv
// Port-level checks on the pixel stream, bound to the top level.
`timescale 1ns / 1ps

module tmcg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic [9:0]  out_pixel_x,
  input logic [7:0]  out_pixel_y,
  input logic        out_last_pixel
);

  // a cell's pixels come out on consecutive cycles
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_pixel |=> out_valid)
    else $error("pixel burst broken before last pixel");

  a_step_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_pixel |=> out_pixel_x == 10'($past(out_pixel_x) + 10'd1))
    else $error("pixel_x did not advance by one");

  a_same_y: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_pixel |=> $stable(out_pixel_y))
    else $error("pixel_y changed within a cell");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_pixel == (out_pixel_x[2:0] == 3'b111)))
    else $error("last pixel flag not on the eighth position");

endmodule

bind text_mode_char_generator tmcg_checker u_tmcg_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_pixel_x    (out_pixel_x),
  .out_pixel_y    (out_pixel_y),
  .out_last_pixel (out_last_pixel)
);
